### rtl/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Operation codes, fixed-point constants and shared types of the histogram
// statistics engine.
// ----------------------------------------------------------------------------
package hse_pkg;

	localparam logic [2:0] OP_RECORD   = 3'd0;
	localparam logic [2:0] OP_MEAN     = 3'd1;
	localparam logic [2:0] OP_STDEV    = 3'd2;
	localparam logic [2:0] OP_PERCENT  = 3'd3;
	localparam logic [2:0] OP_QUANTILE = 3'd4;
	localparam logic [2:0] OP_MAXIMUM  = 3'd5;

	localparam int FIXED_W = 26;
	localparam int INT_W   = 10;
	localparam int ROOT_W  = 64;

	localparam logic [FIXED_W-1:0] FIXED_MAX = '1;
	// 100 in Q.16
	localparam logic [22:0] PCT_SCALE = 23'd6553600;
	localparam logic [15:0] ROUND_UP  = 16'hFFFF;

	typedef struct packed {
		logic start;
		logic div;
	} mdu_req_t;

endpackage

### rtl/hse_ram.sv
// ----------------------------------------------------------------------------
// hse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/hse_mdu.sv
// ----------------------------------------------------------------------------
// hse_mdu
// Shared shift-add multiplier and restoring divider, one bit per cycle.
// ----------------------------------------------------------------------------
module hse_mdu #(
	parameter int WIDTH = 96
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hse_pkg::mdu_req_t   req,
	input  logic [WIDTH-1:0]    a,
	input  logic [WIDTH-1:0]    b,
	output logic                done,
	output logic [WIDTH-1:0]    res
);

	localparam int KW = $clog2(WIDTH + 1);
	localparam logic [1:0] M_IDLE = 2'd0;
	localparam logic [1:0] M_MUL  = 2'd1;
	localparam logic [1:0] M_DIV  = 2'd2;

	logic [1:0]       state_q;
	logic [WIDTH-1:0] a_q, b_q, p_q, r_q;
	logic [KW-1:0]    k_q;
	logic             div_q;
	logic             done_q;
	logic [WIDTH:0]   trial;
	logic             qbit;

	assign trial = {r_q, a_q[WIDTH-1]};
	assign qbit  = (trial >= {1'b0, b_q});
	assign done  = done_q;
	assign res   = div_q ? a_q : p_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done_q  <= 1'b0;
			div_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				M_IDLE: begin
					if (req.start) begin
						a_q   <= a;
						b_q   <= b;
						p_q   <= '0;
						r_q   <= '0;
						k_q   <= KW'(WIDTH);
						div_q <= req.div;
						state_q <= req.div ? M_DIV : M_MUL;
					end
				end
				M_MUL: begin
					if (b_q == '0) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end else begin
						if (b_q[0]) begin
							p_q <= p_q + a_q;
						end
						a_q <= a_q << 1;
						b_q <= b_q >> 1;
					end
				end
				M_DIV: begin
					// quotient bits shift into the numerator register
					r_q <= qbit ? WIDTH'(trial - {1'b0, b_q}) : trial[WIDTH-1:0];
					a_q <= {a_q[WIDTH-2:0], qbit};
					k_q <= k_q - 1'b1;
					if (k_q == KW'(1)) begin
						done_q  <= 1'b1;
						state_q <= M_IDLE;
					end
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

endmodule

### rtl/hse_sqrt.sv
// ----------------------------------------------------------------------------
// hse_sqrt
// Bit-serial integer square root of a 64-bit value, two bits per cycle.
// ----------------------------------------------------------------------------
module hse_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [hse_pkg::ROOT_W-1:0]    x,
	output logic                          done,
	output logic [hse_pkg::ROOT_W/2-1:0]  root
);

	localparam int W = hse_pkg::ROOT_W;

	logic [W-1:0] x_q, res_q, one_q;
	logic         run_q, done_q;
	logic [W-1:0] tsum;

	assign tsum = res_q + one_q;
	assign done = done_q;
	assign root = res_q[W/2-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q   <= x;
				res_q <= '0;
				one_q <= W'(1) << (W - 2);
				run_q <= 1'b1;
			end else if (run_q) begin
				if (x_q >= tsum) begin
					x_q   <= x_q - tsum;
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q <= one_q >> 2;
				if (one_q[0]) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

### rtl/histogram_statistics_engine.sv
// ----------------------------------------------------------------------------
// histogram_statistics_engine
// Histogram of bin counts with total, smallest and largest bin; answers mean,
// standard deviation, within-spread percent, quantile and maximum queries.
// ----------------------------------------------------------------------------
// Record: bin read, then write back, then done. Maximum, rejected and unknown
// requests, mean/percent with no samples and stdev with under two: done on the
// next cycle. Queries walk each bin through S_CHK then S_DAT; mean adds one shared
// multiply per nonzero bin, stdev two (distance squared, then count); percent and
// quantile start with one multiply; mean/stdev/percent end with a divide, stdev
// adds a square root. One request at a time; results show for one cycle with done,
// the receiver cannot stall. Reset: bins are cleared by a pass over every address.
module histogram_statistics_engine #(
	parameter int BIN_COUNT   = 1024,
	parameter int COUNT_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  operation,
	input  logic [15:0] operand_value,
	input  logic [25:0] center,
	input  logic [25:0] spread,
	input  logic [16:0] quantile,
	output logic        done,
	output logic        accepted,
	output logic [25:0] result_fixed,
	output logic [9:0]  result_integer
);

	localparam int BW = $clog2(BIN_COUNT);
	localparam int CW = COUNT_WIDTH;
	localparam int AW = COUNT_WIDTH + 64;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RRD   = 4'd2;
	localparam logic [3:0] S_RWR   = 4'd3;
	localparam logic [3:0] S_PRE   = 4'd4;
	localparam logic [3:0] S_CHK   = 4'd5;
	localparam logic [3:0] S_DAT   = 4'd6;
	localparam logic [3:0] S_SQW   = 4'd7;
	localparam logic [3:0] S_ACCW  = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;
	localparam logic [3:0] S_FMUL  = 4'd10;
	localparam logic [3:0] S_DIVW  = 4'd11;
	localparam logic [3:0] S_ROOTW = 4'd12;

	logic [3:0]    state_q;
	logic [2:0]    op_q;
	logic [15:0]   val_q;
	logic [25:0]   c_q;
	logic [CW-1:0] total_q;
	logic [BW:0]   small_q;
	logic [BW-1:0] large_q;
	logic [BW:0]   i_q;
	logic [BW-1:0] hi_q;
	logic [BW-1:0] clr_q;
	logic [AW-1:0] acc_q, rank_q;
	logic [CW-1:0] cnt_q;
	logic          done_q, acc_out_q;
	logic [25:0]   fixed_q;
	logic [9:0]    int_q;

	hse_pkg::mdu_req_t mreq_q;
	logic [AW-1:0] ma_q, mb_q, mres;
	logic          mdone;
	logic          sq_go_q, sq_done;
	logic [hse_pkg::ROOT_W-1:0]   sq_x_q;
	logic [hse_pkg::ROOT_W/2-1:0] sq_root;

	logic          we;
	logic [BW-1:0] waddr, raddr;
	logic [CW-1:0] wdata, rdata;

	logic [AW-1:0] xw, cw, dw, ns, lo_w, hi_w, lo_e, hi_e, run, fsat;
	logic [BW-1:0] vidx;

	assign vidx = val_q[BW-1:0];
	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign accepted = acc_out_q;
	assign result_fixed = fixed_q;
	assign result_integer = int_q;

	always_comb begin
		xw   = AW'(i_q[BW-1:0]) << 16;
		cw   = AW'(c_q);
		dw   = (xw >= cw) ? (xw - cw) : (cw - xw);
		ns   = mres;
		lo_w = (cw >= ns) ? ((cw - ns + AW'(hse_pkg::ROUND_UP)) >> 16) : '0;
		hi_w = (cw + ns + AW'(hse_pkg::ROUND_UP)) >> 16;
		lo_e = (lo_w > AW'(small_q)) ? lo_w : AW'(small_q);
		hi_e = (hi_w < AW'(large_q)) ? hi_w : AW'(large_q);
		run  = acc_q + AW'(rdata);
		fsat = (mres > AW'(hse_pkg::FIXED_MAX)) ? AW'(hse_pkg::FIXED_MAX) : mres;
	end

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = '0;
		raddr = (state_q == S_RRD) ? vidx : i_q[BW-1:0];
		if (state_q == S_CLR) begin
			we = 1'b1;
		end else if (state_q == S_RWR) begin
			we    = 1'b1;
			waddr = vidx;
			wdata = rdata + 1'b1;
		end
	end

	hse_ram #(.WIDTH(CW), .DEPTH(BIN_COUNT)) u_bins (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	hse_mdu #(.WIDTH(AW)) u_mdu (
		.clk(clk), .arst_n(arst_n), .req(mreq_q), .a(ma_q), .b(mb_q),
		.done(mdone), .res(mres)
	);

	hse_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_go_q), .x(sq_x_q),
		.done(sq_done), .root(sq_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			clr_q     <= '0;
			total_q   <= '0;
			small_q   <= '1;
			large_q   <= '0;
			done_q    <= 1'b0;
			acc_out_q <= 1'b0;
			fixed_q   <= '0;
			int_q     <= '0;
			mreq_q    <= '0;
			sq_go_q   <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			mreq_q.start <= 1'b0;
			sq_go_q      <= 1'b0;
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BIN_COUNT - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						op_q      <= operation;
						val_q     <= operand_value;
						c_q       <= center;
						acc_q     <= '0;
						i_q       <= small_q;
						hi_q      <= large_q;
						acc_out_q <= 1'b1;
						fixed_q   <= '0;
						int_q     <= '0;
						case (operation)
							hse_pkg::OP_RECORD: begin
								if (17'(operand_value) >= 17'(BIN_COUNT) || total_q == '1) begin
									acc_out_q <= 1'b0;
									done_q    <= 1'b1;
								end else begin
									state_q <= S_RRD;
								end
							end
							hse_pkg::OP_MEAN, hse_pkg::OP_PERCENT: begin
								if (total_q == '0) begin
									done_q <= 1'b1;
								end else if (operation == hse_pkg::OP_MEAN) begin
									state_q <= S_CHK;
								end else begin
									mreq_q  <= '{start: 1'b1, div: 1'b0};
									ma_q    <= AW'(spread);
									mb_q    <= AW'(operand_value);
									state_q <= S_PRE;
								end
							end
							hse_pkg::OP_STDEV: begin
								if (total_q <= CW'(1)) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_CHK;
								end
							end
							hse_pkg::OP_QUANTILE: begin
								mreq_q  <= '{start: 1'b1, div: 1'b0};
								ma_q    <= AW'(total_q);
								mb_q    <= AW'(quantile);
								state_q <= S_PRE;
							end
							hse_pkg::OP_MAXIMUM: begin
								int_q  <= 10'(large_q);
								done_q <= 1'b1;
							end
							default: begin
								acc_out_q <= 1'b0;
								done_q    <= 1'b1;
							end
						endcase
					end
				end
				S_RRD: state_q <= S_RWR;
				S_RWR: begin
					total_q <= total_q + 1'b1;
					if ({1'b0, vidx} < small_q) begin
						small_q <= {1'b0, vidx};
					end
					if (vidx > large_q) begin
						large_q <= vidx;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_PRE: begin
					if (mdone) begin
						state_q <= S_CHK;
						if (op_q == hse_pkg::OP_QUANTILE) begin
							rank_q <= (mres + AW'(hse_pkg::ROUND_UP)) >> 16;
						end else begin
							// clip the window to the bins seen; empty window skips the walk
							hi_q <= hi_e[BW-1:0];
							i_q  <= (lo_e > hi_e) ? ((BW+1)'(hi_e[BW-1:0]) + 1'b1)
								: lo_e[BW:0];
						end
					end
				end
				S_CHK: begin
					state_q <= (i_q <= {1'b0, hi_q}) ? S_DAT : S_FIN;
				end
				S_DAT: begin
					cnt_q   <= rdata;
					state_q <= S_CHK;
					case (op_q)
						hse_pkg::OP_MEAN: begin
							if (rdata != '0) begin
								mreq_q  <= '{start: 1'b1, div: 1'b0};
								ma_q    <= xw;
								mb_q    <= AW'(rdata);
								state_q <= S_ACCW;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end
						hse_pkg::OP_STDEV: begin
							if (rdata != '0) begin
								mreq_q  <= '{start: 1'b1, div: 1'b0};
								ma_q    <= dw;
								mb_q    <= dw;
								state_q <= S_SQW;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end
						hse_pkg::OP_PERCENT: begin
							acc_q <= run;
							i_q   <= i_q + 1'b1;
						end
						hse_pkg::OP_QUANTILE: begin
							acc_q <= run;
							if (run >= rank_q) begin
								int_q   <= 10'(i_q[BW-1:0]);
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_SQW: begin
					if (mdone) begin
						mreq_q  <= '{start: 1'b1, div: 1'b0};
						ma_q    <= mres;
						mb_q    <= AW'(cnt_q);
						state_q <= S_ACCW;
					end
				end
				S_ACCW: begin
					if (mdone) begin
						acc_q   <= acc_q + mres;
						i_q     <= i_q + 1'b1;
						state_q <= S_CHK;
					end
				end
				S_FIN: begin
					case (op_q)
						hse_pkg::OP_MEAN: begin
							// the sum already carries the 16 fraction bits of each bin
							mreq_q  <= '{start: 1'b1, div: 1'b1};
							ma_q    <= acc_q;
							mb_q    <= AW'(total_q);
							state_q <= S_DIVW;
						end
						hse_pkg::OP_STDEV: begin
							mreq_q  <= '{start: 1'b1, div: 1'b1};
							ma_q    <= acc_q;
							mb_q    <= AW'(total_q - 1'b1);
							state_q <= S_DIVW;
						end
						hse_pkg::OP_PERCENT: begin
							mreq_q  <= '{start: 1'b1, div: 1'b0};
							ma_q    <= acc_q;
							mb_q    <= AW'(hse_pkg::PCT_SCALE);
							state_q <= S_FMUL;
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_FMUL: begin
					if (mdone) begin
						mreq_q  <= '{start: 1'b1, div: 1'b1};
						ma_q    <= mres;
						mb_q    <= AW'(total_q);
						state_q <= S_DIVW;
					end
				end
				S_DIVW: begin
					if (mdone) begin
						if (op_q == hse_pkg::OP_STDEV) begin
							// clip the variance to 64 bits before the root
							sq_x_q  <= (mres[AW-1:64] != '0) ? '1 : mres[63:0];
							sq_go_q <= 1'b1;
							state_q <= S_ROOTW;
						end else begin
							fixed_q <= fsat[25:0];
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					end
				end
				S_ROOTW: begin
					if (sq_done) begin
						fixed_q <= (sq_root > 32'(hse_pkg::FIXED_MAX)) ? hse_pkg::FIXED_MAX
							: sq_root[25:0];
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result shown while busy");

	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done)) else $error("request dropped");

	a_seen_order: assert property (@(posedge clk) disable iff (!arst_n)
		(total_q != '0) |-> (small_q <= {1'b0, large_q}))
		else $error("smallest above largest");

endmodule

### sim/histogram_statistics_engine_test.sv
// ----------------------------------------------------------------------------
// histogram_statistics_engine_test
// Self-checking bench for the histogram statistics engine: directed requests
// for the empty, single-sample, window and quantile corner cases, then random
// record and query traffic checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module histogram_statistics_engine_test;

	localparam logic [2:0] OP_UNUSED_LO = 3'd6;
	localparam logic [2:0] OP_UNUSED_HI = 3'd7;
	localparam int BINS = 1024;

	typedef struct {
		logic [2:0]  op;
		logic [15:0] val;
		logic [25:0] ctr;
		logic [25:0] spr;
		logic [16:0] qnt;
	} request_t;

	typedef struct {
		logic        acc;
		logic [25:0] fx;
		logic [9:0]  iv;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  operation;
	logic [15:0] operand_value;
	logic [25:0] center;
	logic [25:0] spread;
	logic [16:0] quantile;
	logic        done;
	logic        accepted;
	logic [25:0] result_fixed;
	logic [9:0]  result_integer;

	request_t pending_requests[$];
	answer_t  expected_answers[$];
	int       error_count;
	int       idle_cycles;

	// predictor copy of the histogram
	logic [31:0] bin_tally[BINS];
	logic [31:0] sample_total;
	logic [10:0] lowest_bin;
	logic [9:0]  highest_bin;

	histogram_statistics_engine dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .operand_value(operand_value), .center(center),
		.spread(spread), .quantile(quantile), .done(done), .accepted(accepted),
		.result_fixed(result_fixed), .result_integer(result_integer)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic logic [63:0] quotient_sat(logic [127:0] num, logic [63:0] den);
		logic [127:0] q;
		q = num / den;
		return (q[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : q[63:0];
	endfunction

	function automatic logic [25:0] clamp_fixed(logic [63:0] v);
		return (v > 64'(hse_pkg::FIXED_MAX)) ? hse_pkg::FIXED_MAX : v[25:0];
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] one;
		r = 0;
		one = 64'h1 << 62;
		while (one > x)
			one >>= 2;
		while (one != 0) begin
			if (x >= r + one) begin
				x = x - (r + one);
				r = (r >> 1) + one;
			end else begin
				r >>= 1;
			end
			one >>= 2;
		end
		return r;
	endfunction

	function automatic answer_t histogram_answer(request_t rq);
		answer_t a;
		logic [127:0] acc;
		logic [63:0] d, ns, lo, hi, in_window, rank, run;
		a.acc = 1'b1;
		a.fx = '0;
		a.iv = '0;
		acc = '0;
		case (rq.op)
			hse_pkg::OP_RECORD: begin
				if (rq.val >= BINS || sample_total == 32'hFFFF_FFFF) begin
					a.acc = 1'b0;
				end else begin
					sample_total++;
					bin_tally[rq.val[9:0]]++;
					if (rq.val < lowest_bin) lowest_bin = rq.val[10:0];
					if (rq.val > highest_bin) highest_bin = rq.val[9:0];
				end
			end
			hse_pkg::OP_MEAN: begin
				if (sample_total != 0) begin
					for (int i = lowest_bin; i <= highest_bin && i < BINS; i++)
						acc += 128'(bin_tally[i]) * 128'(i);
					a.fx = clamp_fixed(quotient_sat(acc << 16, 64'(sample_total)));
				end
			end
			hse_pkg::OP_STDEV: begin
				if (sample_total > 1) begin
					for (int i = lowest_bin; i <= highest_bin && i < BINS; i++) begin
						d = (64'(i) << 16);
						d = (d >= 64'(rq.ctr)) ? d - 64'(rq.ctr) : 64'(rq.ctr) - d;
						acc += 128'(d * d) * 128'(bin_tally[i]);
					end
					a.fx = clamp_fixed(root_floor(quotient_sat(acc,
						64'(sample_total) - 64'd1)));
				end
			end
			hse_pkg::OP_PERCENT: begin
				if (sample_total != 0) begin
					ns = 64'(rq.val) * 64'(rq.spr);
					lo = (64'(rq.ctr) >= ns) ? (64'(rq.ctr) - ns + 64'hFFFF) >> 16 : 0;
					if (lo < 64'(lowest_bin)) lo = 64'(lowest_bin);
					hi = (64'(rq.ctr) + ns + 64'hFFFF) >> 16;
					if (hi > 64'(highest_bin)) hi = 64'(highest_bin);
					in_window = 0;
					for (logic [63:0] i = lo; i <= hi && i < BINS; i++)
						in_window += 64'(bin_tally[i]);
					a.fx = clamp_fixed(quotient_sat(128'(in_window) * 128'(hse_pkg::PCT_SCALE),
						64'(sample_total)));
				end
			end
			hse_pkg::OP_QUANTILE: begin
				rank = (64'(rq.qnt) * 64'(sample_total) + 64'(hse_pkg::ROUND_UP)) >> 16;
				run = 0;
				for (int i = lowest_bin; i <= highest_bin && i < BINS; i++) begin
					run += 64'(bin_tally[i]);
					if (run >= rank) begin
						a.iv = i[9:0];
						break;
					end
				end
			end
			hse_pkg::OP_MAXIMUM: a.iv = highest_bin;
			default: a.acc = 1'b0;
		endcase
		return a;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) return 0;
		if (r < 9) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// driver: hold the request until accepted, then load the next or idle
	always @(posedge clk or negedge arst_n) begin
		request_t rq;
		if (!arst_n) begin
			start <= 1'b0;
			idle_cycles <= 0;
			operation <= hse_pkg::OP_RECORD;
			operand_value <= '0;
			center <= '0;
			spread <= '0;
			quantile <= '0;
		end else begin
			if (start && !busy) begin
				rq.op = operation;
				rq.val = operand_value;
				rq.ctr = center;
				rq.spr = spread;
				rq.qnt = quantile;
				expected_answers.push_back(histogram_answer(rq));
				idle_cycles <= pick_gap();
				start <= 1'b0;
			end else if (!start) begin
				if (idle_cycles > 0) begin
					idle_cycles <= idle_cycles - 1;
				end else if (pending_requests.size() > 0) begin
					rq = pending_requests.pop_front();
					operation <= rq.op;
					operand_value <= rq.val;
					center <= rq.ctr;
					spread <= rq.spr;
					quantile <= rq.qnt;
					start <= 1'b1;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				e = expected_answers.pop_front();
				if (accepted !== e.acc) report_mismatch("accepted", accepted, e.acc);
				if (result_fixed !== e.fx) report_mismatch("result_fixed", result_fixed, e.fx);
				if (result_integer !== e.iv)
					report_mismatch("result_integer", result_integer, e.iv);
			end
		end
	end

	task automatic add_request(logic [2:0] op, logic [15:0] val, logic [25:0] ctr,
			logic [25:0] spr, logic [16:0] qnt);
		request_t rq;
		rq.op = op;
		rq.val = val;
		rq.ctr = ctr;
		rq.spr = spr;
		rq.qnt = qnt;
		pending_requests.push_back(rq);
	endtask

	initial begin
		int r;
		logic [2:0] op;
		logic [25:0] ctr, spr;
		logic [16:0] qnt;
		error_count = 0;
		sample_total = 0;
		lowest_bin = 11'h7FF;
		highest_bin = 0;
		foreach (bin_tally[i]) bin_tally[i] = 0;
		arst_n = 1'b0;

		// empty histogram, unused codes, rejects, single sample, windows, quantiles
		add_request(hse_pkg::OP_MEAN, 0, 0, 0, 0);
		add_request(hse_pkg::OP_STDEV, 0, 0, 0, 0);
		add_request(hse_pkg::OP_PERCENT, 16'hFFFF, '1, '1, 0);
		add_request(hse_pkg::OP_QUANTILE, 0, 0, 0, 17'd65536);
		add_request(hse_pkg::OP_MAXIMUM, 0, 0, 0, 0);
		add_request(OP_UNUSED_LO, '1, '1, '1, '1);
		add_request(OP_UNUSED_HI, 0, 0, 0, 0);
		add_request(hse_pkg::OP_RECORD, 16'd1024, 0, 0, 0);
		add_request(hse_pkg::OP_RECORD, 16'hFFFF, 0, 0, 0);
		add_request(hse_pkg::OP_RECORD, 16'd200, 0, 0, 0);
		add_request(hse_pkg::OP_STDEV, 0, 26'd200 << 16, 0, 0);
		add_request(hse_pkg::OP_RECORD, 16'd200, 0, 0, 0);
		add_request(hse_pkg::OP_RECORD, 16'd210, 0, 0, 0);
		add_request(hse_pkg::OP_MEAN, 0, 0, 0, 0);
		add_request(hse_pkg::OP_STDEV, 0, 0, 0, 0);
		add_request(hse_pkg::OP_STDEV, 0, '1, 0, 0);
		add_request(hse_pkg::OP_PERCENT, 0, 26'd200 << 16, 0, 0);
		add_request(hse_pkg::OP_PERCENT, 0, '1, 0, 0);
		add_request(hse_pkg::OP_PERCENT, 16'hFFFF, 26'd205 << 16, '1, 0);
		add_request(hse_pkg::OP_QUANTILE, 0, 0, 0, 0);
		add_request(hse_pkg::OP_QUANTILE, 0, 0, 0, 17'd65536);
		add_request(hse_pkg::OP_QUANTILE, 0, 0, 0, 17'd65537);
		add_request(hse_pkg::OP_QUANTILE, 0, 0, 0, '1);
		add_request(hse_pkg::OP_MAXIMUM, 0, 0, 0, 0);

		// random traffic kept to a narrow band so that query walks stay short
		for (int k = 0; k < 2000; k++) begin
			r = $urandom_range(0, 99);
			ctr = ($urandom_range(0, 3) == 0) ? 26'($urandom)
				: 26'(($urandom_range(180, 240) << 16) | $urandom_range(0, 65535));
			spr = ($urandom_range(0, 3) == 0) ? 26'($urandom) : 26'($urandom_range(0, 262143));
			qnt = ($urandom_range(0, 4) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
			if (r < 60) begin
				op = hse_pkg::OP_RECORD;
				add_request(op, ($urandom_range(0, 9) == 0) ? 16'($urandom)
					: 16'($urandom_range(192, 223)), ctr, spr, qnt);
			end else begin
				if (r < 98) op = 3'($urandom_range(1, 5));
				else op = 3'($urandom_range(6, 7));
				add_request(op, ($urandom_range(0, 3) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, 8)), ctr, spr, qnt);
			end
		end

		// widen the span to both ends of the bin range last
		add_request(hse_pkg::OP_RECORD, 16'd0, 0, 0, 0);
		add_request(hse_pkg::OP_RECORD, 16'd1023, 0, 0, 0);
		add_request(hse_pkg::OP_MEAN, 0, 0, 0, 0);
		add_request(hse_pkg::OP_STDEV, 0, '1, 0, 0);
		add_request(hse_pkg::OP_PERCENT, 16'd3, 26'd512 << 16, 26'd100 << 16, 0);
		add_request(hse_pkg::OP_QUANTILE, 0, 0, 0, 17'd32768);
		add_request(hse_pkg::OP_QUANTILE, 0, 0, 0, 17'd65536);
		add_request(hse_pkg::OP_MAXIMUM, 0, 0, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (pending_requests.size() > 0 || start || expected_answers.size() > 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("** histogram_statistics_engine: PASSED **");
		else
			$display("** histogram_statistics_engine: FAILED **");
		$finish;
	end

	initial begin
		#400ms;
		$display("** histogram_statistics_engine: FAILED **");
		$finish;
	end

endmodule
